// ===== rtl/dpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared types and constants of the dpcm prefix-class pixel encoder.
// ----------------------------------------------------------------------------
package dpcm_pkg;

  localparam int MAX_CHANNELS = 3;
  localparam int NUM_CLASSES  = 4;
  localparam int MAX_RESULTS  = 3;
  localparam int FIFO_DEPTH   = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 4;
  localparam int CH_W         = 2;
  localparam int CODE_W       = 11;

  // class prefixes 0, 10, 110, 111
  localparam logic [2:0] PREFIX_CODE [NUM_CLASSES] = '{3'd0, 3'd2, 3'd6, 3'd7};
  localparam logic [3:0] PREFIX_LEN  [NUM_CLASSES] = '{4'd1, 4'd2, 4'd3, 4'd3};

  localparam logic [2:0] CFG_COLOR_MODE  = 3'd0;
  localparam logic [2:0] CFG_CLASS0_BITS = 3'd1;
  localparam logic [2:0] CFG_CLASS1_BITS = 3'd2;
  localparam logic [2:0] CFG_CLASS2_BITS = 3'd3;
  localparam logic [2:0] CFG_CLASS3_BITS = 3'd4;

  typedef struct packed {
    logic [7:0] sample;
    logic       first_of_image;
    logic       last_of_image;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_seed;
    logic       run_end;
    logic       image_end;
  } out_word_t;

  typedef struct packed {
    logic                        color_mode;
    logic [NUM_CLASSES-1:0][3:0] class_bits;
  } cfg_t;

  // words produced by one sample, slot 0 first
  typedef struct packed {
    logic [1:0]                  count;
    out_word_t [MAX_RESULTS-1:0] slot;
  } batch_t;

endpackage

// ===== rtl/dpcm_prefix_class_pixel_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// dpcm_prefix_class_pixel_encoder_unit
// Dpcm pixel encoder with prefix-class codes, byte-wide output stream.
// ----------------------------------------------------------------------------
// A sample enters an input register, is coded into zero to three output words
// (seed byte, full code bytes, flush byte) and pushed into an eight-entry
// output queue; the output port moves one word per cycle while out_ready is
// high. The encode stage waits while fewer than three queue entries are free.
// Configuration registers may only be written while the block is idle; there
// is no clearing pass after reset.
module dpcm_prefix_class_pixel_encoder_unit #(
  parameter int MAX_CHANNELS = dpcm_pkg::MAX_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dpcm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpcm_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [dpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dpcm_pkg::cfg_t     cfg;
  dpcm_pkg::in_word_t hold_word;
  logic               hold_valid;
  logic               fire;
  logic               room;
  dpcm_pkg::batch_t   batch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode    <= 1'b0;
      cfg.class_bits[0] <= 4'd1;
      cfg.class_bits[1] <= 4'd2;
      cfg.class_bits[2] <= 4'd4;
      cfg.class_bits[3] <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpcm_pkg::CFG_COLOR_MODE:  cfg.color_mode    <= cfg_data[0];
        dpcm_pkg::CFG_CLASS0_BITS: cfg.class_bits[0] <= cfg_data;
        dpcm_pkg::CFG_CLASS1_BITS: cfg.class_bits[1] <= cfg_data;
        dpcm_pkg::CFG_CLASS2_BITS: cfg.class_bits[2] <= cfg_data;
        dpcm_pkg::CFG_CLASS3_BITS: cfg.class_bits[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_data;
    end
  end

  dpcm_encode_core #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (hold_word),
    .fire (fire),
    .batch(batch)
  );

  dpcm_byte_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .batch    (batch),
    .pop      (out_valid && out_ready),
    .head     (out_data),
    .not_empty(out_valid),
    .room     (room)
  );

endmodule

// ===== rtl/dpcm_encode_core.sv =====
// ----------------------------------------------------------------------------
// dpcm_encode_core
// Channel state, prediction, class coding and bit packing of one sample.
// ----------------------------------------------------------------------------
module dpcm_encode_core #(
  parameter int MAX_CHANNELS = dpcm_pkg::MAX_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  dpcm_pkg::cfg_t    cfg,
  input  dpcm_pkg::in_word_t item,
  input  logic              fire,
  output dpcm_pkg::batch_t  batch
);

  localparam int IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RGB_CHANS = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

  logic [6:0] prev_halved [MAX_CHANNELS];
  logic [7:0] bit_acc;
  logic [2:0] bits_pending;
  logic [dpcm_pkg::CH_W-1:0] channel_index;
  logic [1:0] seeds_done;

  logic [dpcm_pkg::CH_W-1:0] chans, ch0, ch, ch_next;
  logic [1:0]  seeds0, seeds_next;
  logic [7:0]  acc0, acc_next;
  logic [2:0]  pend0, pend_next;
  logic        seed;
  logic [6:0]  halved, prev;
  logic [7:0]  diff, folded;
  logic [3:0]  nb [dpcm_pkg::NUM_CLASSES];
  logic [10:0] lo [dpcm_pkg::NUM_CLASSES+1];
  logic        hit;
  logic [1:0]  q_sel;
  logic [3:0]  code_len;
  logic [dpcm_pkg::CODE_W-1:0] code;
  logic [4:0]  total;
  logic [18:0] packed_bits;
  logic [23:0] window;
  logic [1:0]  nfull;
  logic [2:0]  rem;
  logic        flush;
  logic [7:0]  wb [dpcm_pkg::MAX_RESULTS];
  logic [1:0]  count;

  always_comb begin
    chans  = cfg.color_mode ? dpcm_pkg::CH_W'(RGB_CHANS) : dpcm_pkg::CH_W'(1);
    ch0    = item.first_of_image ? '0 : channel_index;
    seeds0 = item.first_of_image ? '0 : seeds_done;
    acc0   = item.first_of_image ? '0 : bit_acc;
    pend0  = item.first_of_image ? '0 : bits_pending;
    ch     = (ch0 >= chans) ? '0 : ch0;
    seed   = ({1'b0, seeds0} < {1'b0, chans});
    halved = item.sample[7:1];
    prev   = prev_halved[ch[IDX_W-1:0]];
    diff   = {1'b0, halved} - {1'b0, prev};
    // zigzag fold: 2d for d >= 0, -2d-1 otherwise
    folded = {diff[6:0], 1'b0} ^ {8{diff[7]}};
  end

  // cumulative class bounds and first class that holds the folded value
  always_comb begin
    lo[0] = '0;
    for (int q = 0; q < dpcm_pkg::NUM_CLASSES; q++) begin
      nb[q]   = (cfg.class_bits[q] > 4'd8) ? 4'd8 : cfg.class_bits[q];
      lo[q+1] = lo[q] + (11'd1 << nb[q]);
    end
    hit   = 1'b0;
    q_sel = '0;
    for (int q = 0; q < dpcm_pkg::NUM_CLASSES; q++) begin
      if (!hit && ({3'b0, folded} < lo[q+1])) begin
        hit   = 1'b1;
        q_sel = 2'(q);
      end
    end
  end

  always_comb begin
    if (seed || !hit) begin
      code_len = '0;
      code     = '0;
    end else begin
      code_len = dpcm_pkg::PREFIX_LEN[q_sel] + nb[q_sel];
      code     = (dpcm_pkg::CODE_W'(dpcm_pkg::PREFIX_CODE[q_sel]) << nb[q_sel])
               | ({3'b0, folded} - lo[q_sel]);
    end
    total       = {2'b0, pend0} + {1'b0, code_len};
    packed_bits = ({11'b0, acc0} << code_len) | {8'b0, code};
    // left-align pending and new bits, msb first
    window      = {5'b0, packed_bits} << (5'd24 - total);
    nfull       = total[4:3];
    rem         = total[2:0];
    flush       = item.last_of_image && (rem != '0);
    acc_next    = packed_bits[7:0] & ~(8'hFF << rem);
    for (int k = 0; k < dpcm_pkg::MAX_RESULTS; k++) begin
      wb[k] = window[23-8*k -: 8];
    end
    count = seed ? (2'd1 + {1'b0, flush}) : (nfull + {1'b0, flush});
  end

  always_comb begin
    batch.count = count;
    for (int k = 0; k < dpcm_pkg::MAX_RESULTS; k++) begin
      batch.slot[k] = '0;
    end
    if (seed) begin
      batch.slot[0].out_byte = item.sample;
      batch.slot[0].is_seed  = 1'b1;
      batch.slot[1].out_byte = wb[0];
    end else begin
      for (int k = 0; k < dpcm_pkg::MAX_RESULTS; k++) begin
        batch.slot[k].out_byte = wb[k];
      end
    end
    for (int k = 0; k < dpcm_pkg::MAX_RESULTS; k++) begin
      if (count != '0 && 2'(k) == count - 2'd1) begin
        batch.slot[k].run_end   = 1'b1;
        batch.slot[k].image_end = item.last_of_image;
      end
    end
  end

  always_comb begin
    if (item.last_of_image) begin
      ch_next    = '0;
      seeds_next = '0;
      pend_next  = '0;
    end else begin
      ch_next    = ({1'b0, ch} + 3'd1 >= {1'b0, chans}) ? '0 : ch + 2'd1;
      seeds_next = seed ? seeds0 + 2'd1 : seeds0;
      pend_next  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_acc       <= '0;
      bits_pending  <= '0;
      channel_index <= '0;
      seeds_done    <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        prev_halved[i] <= '0;
      end
    end else if (fire) begin
      bit_acc       <= item.last_of_image ? '0 : acc_next;
      bits_pending  <= pend_next;
      channel_index <= ch_next;
      seeds_done    <= seeds_next;
      prev_halved[ch[IDX_W-1:0]] <= halved;
    end
  end

endmodule

// ===== rtl/dpcm_byte_fifo.sv =====
// ----------------------------------------------------------------------------
// dpcm_byte_fifo
// Output word queue: takes up to three words a cycle, hands out one.
// ----------------------------------------------------------------------------
module dpcm_byte_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dpcm_pkg::batch_t    batch,
  input  logic                pop,
  output dpcm_pkg::out_word_t head,
  output logic                not_empty,
  output logic                room
);

  localparam int PTR_W = $clog2(dpcm_pkg::FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  dpcm_pkg::out_word_t mem [dpcm_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] push_n;

  assign push_n    = push ? CNT_W'(batch.count) : '0;
  assign not_empty = (count != '0);
  assign room      = (count <= CNT_W'(dpcm_pkg::FIFO_DEPTH - dpcm_pkg::MAX_RESULTS));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < dpcm_pkg::MAX_RESULTS; k++) begin
        if (2'(k) < batch.count) begin
          mem[wr_ptr + PTR_W'(k)] <= batch.slot[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PTR_W-1:0];
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + push_n - CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/dpcm_checker.sv =====
// ----------------------------------------------------------------------------
// dpcm_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dpcm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dpcm_pkg::out_word_t out_data
);

  // queue and input register empty after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word shown right after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // the last word of an image is also the last word of its sample
  a_image_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.image_end |-> out_data.run_end)
    else $error("image_end without run_end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind dpcm_prefix_class_pixel_encoder_unit dpcm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
